// ===== hdl/pcpc_pkg.sv =====
// shared types, codes and constants of the proximity count calibrator
package pcpc_pkg;

  localparam int COUNT_W   = 16;
  localparam int SAMPLES_W = 24;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COUNT_W-1:0] prox_count;
    logic [31:0]        time_us;
    logic               restore_valid;
    logic [COUNT_W-1:0] restore_min;
    logic [COUNT_W-1:0] restore_max;
    logic [COUNT_W-1:0] restore_park;
  } req_t;

  typedef struct packed {
    logic [15:0]        position;
    logic [COUNT_W-1:0] echo_count;
    logic [15:0]        zero_position;
    logic [15:0]        max_position;
    logic [COUNT_W-1:0] min_count_out;
    logic [COUNT_W-1:0] max_count_out;
    logic [COUNT_W-1:0] park_count_out;
  } res_t;

  typedef logic [4:0] cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cal;
    logic       samples_zero;
    logic       last_le_dc;
    logic       den_zero;
    logic       div_busy;
    logic       sqrt_busy;
  } status_t;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_BEGIN   = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;
  localparam logic [1:0] OP_RESTORE = 2'd3;

  localparam cmd_t CMD_NONE     = 5'd0;
  localparam cmd_t CMD_LOAD     = 5'd1;
  localparam cmd_t CMD_APPLY    = 5'd2;
  localparam cmd_t CMD_PARK_DIV = 5'd3;
  localparam cmd_t CMD_PARK_SET = 5'd4;
  localparam cmd_t CMD_REC_PREP = 5'd5;
  localparam cmd_t CMD_CONV_DIV = 5'd6;
  localparam cmd_t CMD_SQ_START = 5'd7;
  localparam cmd_t CMD_SET_RP   = 5'd8;
  localparam cmd_t CMD_REC_DIV  = 5'd9;
  localparam cmd_t CMD_SET_S    = 5'd10;
  localparam cmd_t CMD_MR_SQRT  = 5'd11;
  localparam cmd_t CMD_MR_R50   = 5'd12;
  localparam cmd_t CMD_MUL_LO   = 5'd13;
  localparam cmd_t CMD_MUL_HI   = 5'd14;
  localparam cmd_t CMD_MUL_SUM  = 5'd15;
  localparam cmd_t CMD_SET_O    = 5'd16;
  localparam cmd_t CMD_CONV_POS = 5'd17;
  localparam cmd_t CMD_CONV_Z   = 5'd18;
  localparam cmd_t CMD_CONV_M   = 5'd19;
  localparam cmd_t CMD_POS_FULL = 5'd20;
  localparam cmd_t CMD_OUT      = 5'd21;

  localparam logic [COUNT_W-1:0] MIN_DEFAULT  = 16'd100;
  localparam logic [COUNT_W-1:0] MAX_DEFAULT  = 16'hFFFF;
  localparam logic [COUNT_W-1:0] PARK_DEFAULT = 16'd20000;
  localparam logic [COUNT_W-1:0] DC_DEFAULT   = 16'd50;
  localparam logic [COUNT_W-1:0] DC_MARGIN    = 16'd50;
  localparam logic [31:0]        WINDOW_DEFAULT = 32'd1000000;
  localparam logic [SAMPLES_W-1:0] SAMPLES_FULL = 24'hFFFFFF;

  // 2^31/sqrt(50), the root of the minimum difference
  localparam logic [31:0] R50     = 32'd303700049;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  // 32767 * 2^47
  localparam logic [63:0] SCALE_NUM = 64'h3FFF_8000_0000_0000;
  localparam logic [47:0] Q48_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [15:0] POS_MAX   = 16'd39320;

endpackage

// ===== hdl/prox_count_to_position_calibrator_top.sv =====
// top level of the proximity count to position calibrator
//
// usage
//  - req channel (req_valid/req_ready/req) takes one item: a sample, begin,
//    end or restore operation; res channel returns exactly one item per
//    request item, in order
//  - cfg_we/cfg_wdata writes the park window in microseconds; write it only
//    while idle, the block itself does not enforce this
//  - the work per item depends on the operation and is set by the radix-2
//    divider and the root unit, shared for every reciprocal root:
//      sample, not calibrating, count at or below dc: full-scale position
//      sample, not calibrating: one root, one product
//      begin or restore: root of park diff, scale divide
//      sample while calibrating: recompute, then root
//      end: optional park average divide, recompute and two products
//  - one item at a time; a new request is taken only after the last result
//    has reached the output register; reset (rst, synchronous) loads the
//    default points and then runs a recompute of scale and offset with req_ready low
//  - a finished item sits in the output register; the next request is
//    still accepted while it waits, and the block stalls only when a second
//    result is ready before the first one was taken
module prox_count_to_position_calibrator_top #(
  parameter int SUM_BITS = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pcpc_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output pcpc_pkg::res_t res,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  import pcpc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  pcpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // park sum width sets the saturation point of the park average
  pcpc_dp #(
    .SUM_BITS (SUM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== hdl/pcpc_div.sv =====
// restoring divider, one quotient bit per cycle
module pcpc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        busy
);

  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh   = {rem, quo[63]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quo  <= {quo[62:0], fits};
      cnt  <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/pcpc_isqrt.sv =====
// integer square root, two radicand bits per cycle
module pcpc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic [31:0] root,
  output logic        busy
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitw;
  logic [63:0] trial;
  logic        take;

  assign trial = res + bitw;
  assign take  = v >= trial;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      v    <= value;
      res  <= '0;
      bitw <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (take) begin
        v   <= v - trial;
        res <= (res >> 1) + bitw;
      end else begin
        res <= res >> 1;
      end
      bitw <= bitw >> 2;
      if (bitw[0]) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/pcpc_ctrl.sv =====
// sequencer that steps the datapath through each item
module pcpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output pcpc_pkg::cmd_t    cmd,
  input  pcpc_pkg::status_t status
);
  import pcpc_pkg::*;

  localparam logic [4:0] ST_INIT   = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_APPLY  = 5'd2;
  localparam logic [4:0] ST_PDIV   = 5'd3;
  localparam logic [4:0] ST_PDIV_W = 5'd4;
  localparam logic [4:0] ST_PSET   = 5'd5;
  localparam logic [4:0] ST_RPREP  = 5'd6;
  localparam logic [4:0] ST_CDIV   = 5'd7;
  localparam logic [4:0] ST_DIVR_W = 5'd8;
  localparam logic [4:0] ST_SQ     = 5'd9;
  localparam logic [4:0] ST_SQ_W   = 5'd10;
  localparam logic [4:0] ST_RDEN   = 5'd11;
  localparam logic [4:0] ST_RDIV   = 5'd12;
  localparam logic [4:0] ST_RDIV_W = 5'd13;
  localparam logic [4:0] ST_RSETS  = 5'd14;
  localparam logic [4:0] ST_CMR    = 5'd15;
  localparam logic [4:0] ST_MLO    = 5'd16;
  localparam logic [4:0] ST_MHI    = 5'd17;
  localparam logic [4:0] ST_MSUM   = 5'd18;
  localparam logic [4:0] ST_MDONE  = 5'd19;
  localparam logic [4:0] ST_MRM    = 5'd20;
  localparam logic [4:0] ST_POST   = 5'd21;
  localparam logic [4:0] ST_OUT    = 5'd22;

  localparam logic [1:0] PH_REC = 2'd0;
  localparam logic [1:0] PH_POS = 2'd1;
  localparam logic [1:0] PH_Z   = 2'd2;
  localparam logic [1:0] PH_M   = 2'd3;

  logic [4:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       init_pend, init_pend_next;
  logic       res_valid_next;

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    init_pend_next = init_pend;
    res_valid_next = res_valid && !res_ready;
    req_ready      = 1'b0;
    cmd            = CMD_NONE;
    case (state)
      ST_INIT: begin
        state_next = ST_RPREP;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd = CMD_APPLY;
        if (status.op == OP_END && !status.samples_zero) begin
          state_next = ST_PDIV;
        end else if (status.op == OP_SAMPLE && !status.cal) begin
          state_next = ST_POST;
        end else begin
          state_next = ST_RPREP;
        end
      end
      ST_PDIV: begin
        cmd        = CMD_PARK_DIV;
        state_next = ST_PDIV_W;
      end
      ST_PDIV_W: begin
        if (!status.div_busy) state_next = ST_PSET;
      end
      ST_PSET: begin
        cmd        = CMD_PARK_SET;
        state_next = ST_RPREP;
      end
      ST_RPREP: begin
        cmd        = CMD_REC_PREP;
        phase_next = PH_REC;
        state_next = ST_DIVR_W;
      end
      ST_CDIV: begin
        cmd        = CMD_CONV_DIV;
        state_next = ST_DIVR_W;
      end
      ST_DIVR_W: begin
        if (!status.div_busy) state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd        = CMD_SQ_START;
        state_next = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (!status.sqrt_busy) begin
          state_next = (phase == PH_REC) ? ST_RDEN : ST_CMR;
        end
      end
      ST_RDEN: begin
        cmd        = CMD_SET_RP;
        state_next = ST_RDIV;
      end
      ST_RDIV: begin
        cmd        = CMD_REC_DIV;
        state_next = status.den_zero ? ST_MLO : ST_RDIV_W;
      end
      ST_RDIV_W: begin
        if (!status.div_busy) state_next = ST_RSETS;
      end
      ST_RSETS: begin
        cmd        = CMD_SET_S;
        state_next = ST_MLO;
      end
      ST_CMR: begin
        cmd        = CMD_MR_SQRT;
        state_next = ST_MLO;
      end
      ST_MLO: begin
        cmd        = CMD_MUL_LO;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd        = CMD_MUL_HI;
        state_next = ST_MSUM;
      end
      ST_MSUM: begin
        cmd        = CMD_MUL_SUM;
        state_next = ST_MDONE;
      end
      ST_MDONE: begin
        case (phase)
          PH_REC: begin
            cmd        = CMD_SET_O;
            state_next = ST_POST;
          end
          PH_POS: begin
            cmd        = CMD_CONV_POS;
            state_next = ST_OUT;
          end
          PH_Z: begin
            cmd        = CMD_CONV_Z;
            phase_next = PH_M;
            state_next = ST_MRM;
          end
          default: begin
            cmd        = CMD_CONV_M;
            state_next = ST_OUT;
          end
        endcase
      end
      ST_MRM: begin
        cmd        = CMD_MR_R50;
        state_next = ST_MLO;
      end
      ST_POST: begin
        if (init_pend) begin
          init_pend_next = 1'b0;
          state_next     = ST_IDLE;
        end else begin
          case (status.op)
            OP_SAMPLE: begin
              if (status.last_le_dc) begin
                cmd        = CMD_POS_FULL;
                state_next = ST_OUT;
              end else begin
                phase_next = PH_POS;
                state_next = ST_CDIV;
              end
            end
            OP_END: begin
              phase_next = PH_Z;
              state_next = ST_MLO;
            end
            default: begin
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!res_valid || res_ready) begin
          cmd            = CMD_OUT;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      phase     <= PH_REC;
      init_pend <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      init_pend <= init_pend_next;
      res_valid <= res_valid_next;
    end
  end

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_REC_PREP || cmd == CMD_CONV_DIV || cmd == CMD_PARK_DIV ||
     cmd == CMD_REC_DIV) |-> !status.div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_SQ_START) |-> (!status.sqrt_busy && !status.div_busy))
    else $error("root started before its radicand was ready");

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_OUT) |=> res_valid)
    else $error("result not presented after being written");

  a_init_hold: assert property (@(posedge clk) disable iff (rst)
    init_pend |-> !req_ready)
    else $error("item taken before the reset recompute finished");

endmodule

// ===== hdl/pcpc_dp.sv =====
// calibration state, root/divide units, multiplier and result register
module pcpc_dp #(
  parameter int SUM_BITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  pcpc_pkg::cmd_t    cmd,
  output pcpc_pkg::status_t status,
  input  pcpc_pkg::req_t    req,
  output pcpc_pkg::res_t    res,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import pcpc_pkg::*;

  localparam logic signed [49:0] SAT_HI  = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SAT_LO  = -SAT_HI;
  localparam logic signed [49:0] O_BASE  = 50'sd429457408;
  localparam logic signed [49:0] POS_LIM = 50'sd2576875520;

  req_t                  req_r;
  logic [COUNT_W-1:0]    min_c, max_c, park_c, last_c, dc;
  logic                  cal;
  logic [31:0]           t0, window;
  logic [SUM_BITS-1:0]   psum;
  logic [SAMPLES_W-1:0]  pcnt;
  logic [47:0]           s_f, s_o;
  logic [31:0]           rp, mr;
  logic [47:0]           plo;
  logic [62:0]           phi;
  logic [48:0]           mres;
  logic [15:0]           res_pos, res_z, res_m;

  logic [COUNT_W-1:0]    min_fix, dc_new, pd, cdiff;
  logic                  den_neg, den_zero;
  logic [31:0]           den_mag;
  logic                  div_start, div_busy, sq_busy;
  logic [63:0]           div_a, div_q;
  logic [31:0]           div_b, sq_root;
  logic [31:0]           elapsed;
  logic [SUM_BITS:0]     sum_add;
  logic [47:0]           a_mag, s_mag;
  logic [31:0]           mul_a;
  logic [63:0]           prod, msum;
  logic [47:0]           m_mag;
  logic signed [49:0]    o_full, d_full;
  logic [47:0]           o_sat;
  logic [15:0]           d_pos;

  assign min_fix  = (min_c < MIN_DEFAULT) ? MIN_DEFAULT : min_c;
  assign dc_new   = min_fix - DC_MARGIN;
  assign pd       = (park_c > dc_new) ? park_c - dc_new : 16'd1;
  assign cdiff    = last_c - dc;
  assign den_zero = rp == R50;
  assign den_neg  = rp > R50;
  assign den_mag  = den_neg ? rp - R50 : R50 - rp;

  always_comb begin
    div_a = ONE_Q62;
    div_b = 32'(pd);
    case (cmd)
      CMD_CONV_DIV: div_b = 32'(cdiff);
      CMD_REC_DIV: begin
        div_a = SCALE_NUM;
        div_b = den_mag;
      end
      CMD_PARK_DIV: begin
        div_a = 64'(psum);
        div_b = 32'(pcnt);
      end
      default: ;
    endcase
  end

  assign div_start = (cmd == CMD_REC_PREP) || (cmd == CMD_CONV_DIV) ||
                     (cmd == CMD_PARK_DIV) || (cmd == CMD_REC_DIV && !den_zero);

  pcpc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .busy(div_busy)
  );

  pcpc_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(cmd == CMD_SQ_START), .value(div_q),
    .root(sq_root), .busy(sq_busy)
  );

  assign elapsed = req_r.time_us - t0;
  assign sum_add = {1'b0, psum} + (SUM_BITS+1)'(req_r.prox_count);

  // magnitude times root, split into two partial products
  assign a_mag = s_f[47] ? 48'(-s_f) : s_f;
  assign mul_a = (cmd == CMD_MUL_LO) ? {16'd0, a_mag[15:0]} : a_mag[47:16];
  assign prod  = mul_a * mr;
  assign msum  = {1'b0, phi} + {16'd0, plo >> 16};
  assign m_mag = msum[62:15];

  assign s_mag = (div_q > {16'd0, Q48_MAX}) ? Q48_MAX : div_q[47:0];

  assign o_full = O_BASE - $signed({mres[48], mres});
  assign o_sat  = (o_full > SAT_HI) ? SAT_HI[47:0] :
                  (o_full < SAT_LO) ? SAT_LO[47:0] : o_full[47:0];

  assign d_full = $signed({{2{s_o[47]}}, s_o}) + $signed({mres[48], mres});
  assign d_pos  = d_full[49] ? 16'd0 : (d_full >= POS_LIM) ? POS_MAX : d_full[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_c  <= MIN_DEFAULT;
      max_c  <= MAX_DEFAULT;
      park_c <= PARK_DEFAULT;
      last_c <= '0;
      dc     <= DC_DEFAULT;
      cal    <= 1'b0;
      t0     <= '0;
      psum   <= '0;
      pcnt   <= '0;
      window <= WINDOW_DEFAULT;
    end else begin
      if (cfg_we) window <= cfg_wdata;
      case (cmd)
        CMD_LOAD: req_r <= req;
        CMD_APPLY: begin
          case (req_r.operation)
            OP_SAMPLE: begin
              last_c <= req_r.prox_count;
              if (cal) begin
                if (req_r.prox_count < min_c) min_c <= req_r.prox_count;
                if (req_r.prox_count > max_c) max_c <= req_r.prox_count;
                if (elapsed < window && pcnt < SAMPLES_FULL) begin
                  psum <= sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
                  pcnt <= pcnt + 24'd1;
                end
              end
            end
            OP_BEGIN: begin
              park_c <= last_c;
              min_c  <= last_c;
              max_c  <= MAX_DEFAULT;
              cal    <= 1'b1;
              t0     <= req_r.time_us;
              psum   <= SUM_BITS'(last_c);
              pcnt   <= 24'd1;
            end
            OP_END: cal <= 1'b0;
            default: begin
              if (req_r.restore_valid) begin
                min_c  <= req_r.restore_min;
                max_c  <= req_r.restore_max;
                park_c <= req_r.restore_park;
              end else begin
                min_c  <= MIN_DEFAULT;
                max_c  <= MAX_DEFAULT;
                park_c <= PARK_DEFAULT;
              end
            end
          endcase
        end
        CMD_PARK_SET: park_c <= (div_q > 64'(MAX_DEFAULT)) ? MAX_DEFAULT : div_q[15:0];
        CMD_REC_PREP: begin
          min_c <= min_fix;
          dc    <= dc_new;
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SET_RP: begin
        rp <= sq_root;
        mr <= sq_root;
      end
      CMD_REC_DIV: if (den_zero) s_f <= Q48_MAX;
      CMD_SET_S:   s_f <= den_neg ? 48'(-s_mag) : s_mag;
      CMD_MR_SQRT: mr <= sq_root;
      CMD_MR_R50:  mr <= R50;
      CMD_MUL_LO:  plo <= prod[47:0];
      CMD_MUL_HI:  phi <= prod[62:0];
      CMD_MUL_SUM: mres <= s_f[47] ? 49'(-{1'b0, m_mag}) : {1'b0, m_mag};
      CMD_SET_O:   s_o <= o_sat;
      CMD_CONV_POS: res_pos <= d_pos;
      CMD_CONV_Z:   res_z <= d_pos;
      CMD_CONV_M:   res_m <= d_pos;
      CMD_POS_FULL: res_pos <= POS_MAX;
      CMD_OUT: begin
        res.echo_count     <= last_c;
        res.position       <= (req_r.operation == OP_SAMPLE) ? res_pos : 16'd0;
        res.zero_position  <= (req_r.operation == OP_END) ? res_z : 16'd0;
        res.max_position   <= (req_r.operation == OP_END) ? res_m : 16'd0;
        res.min_count_out  <= (req_r.operation == OP_END) ? min_c : '0;
        res.max_count_out  <= (req_r.operation == OP_END) ? max_c : '0;
        res.park_count_out <= (req_r.operation == OP_END) ? park_c : '0;
      end
      default: ;
    endcase
  end

  assign status.op           = req_r.operation;
  assign status.cal          = cal;
  assign status.samples_zero = pcnt == '0;
  assign status.last_le_dc   = last_c <= dc;
  assign status.den_zero     = den_zero;
  assign status.div_busy     = div_busy;
  assign status.sqrt_busy    = sq_busy;

endmodule
